// File: design/uts_pkg.sv
// Shared types and codes for the urgency-tier thread scheduler.
`timescale 1ns / 1ps
`default_nettype none
package uts_pkg;
  typedef enum logic [2:0] {
    REQ_ADD = 3'd0, REQ_START = 3'd1, REQ_PICK = 3'd2, REQ_RETURN = 3'd3, REQ_NOTIFY = 3'd4
  } req_e;
  typedef enum logic [2:0] {
    ST_CREATED = 3'd0, ST_READY = 3'd1, ST_RUNNING = 3'd2, ST_YIELDED = 3'd3,
    ST_WAITING = 3'd4, ST_NOW = 3'd5, ST_FINISHED = 3'd6
  } run_e;
  localparam logic [2:0] STAT_DONE = 3'd0;
  localparam logic [2:0] STAT_RUN = 3'd1;
  localparam logic [2:0] STAT_ALL_FIN = 3'd2;
  localparam logic [2:0] STAT_ALL_WAIT = 3'd3;
  localparam logic [2:0] STAT_NO_RUN = 3'd4;
  localparam logic [2:0] STAT_BUSY = 3'd5;
  localparam logic [1:0] OC_WAIT = 2'd1;
  localparam logic [1:0] OC_FINISH = 2'd2;
  localparam int InBits = 3 + 3 + 8 + 16 + 32 + 2 + 32 + 16 + 32 + 1;
  localparam int InBytes = (InBits + 7) / 8;
  localparam int OutBits = 3 + 3 + 32 + 2 + 32 + 4;
  localparam int OutBytes = (OutBits + 7) / 8;
  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  chosen_thread;
    logic [31:0] sleep_time;
    logic [1:0]  urgency;
    logic [31:0] resume_value;
    logic [3:0]  woken_count;
  } result_t;
endpackage
`default_nettype wire

// File: design/uts_core.sv
// Sequencer over the thread table memory: add, start, sort-and-pick, return, notify.
`timescale 1ns / 1ps
`default_nettype none
module uts_core import uts_pkg::*; #(
  parameter int NUM_THREADS = 8,
  parameter int TIME_BITS = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [2:0]   req_type_i,
  input  wire logic [2:0]   thread_id_i,
  input  wire logic [7:0]   priority_req_i,
  input  wire logic [15:0]  nice_i,
  input  wire logic [31:0]  now_i,
  input  wire logic [1:0]   outcome_i,
  input  wire logic [31:0]  wait_key_i,
  input  wire logic [15:0]  wait_param_i,
  input  wire logic [31:0]  wake_value_i,
  input  wire logic         wake_all_i,
  output logic              busy_o,
  output logic              done_o,
  output result_t           res_o
);
  localparam int IW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
  localparam int CW = $clog2(NUM_THREADS + 1);
  localparam int TW = TIME_BITS;

  typedef struct packed {
    logic [2:0]    rs;
    logic [7:0]    prio;
    logic [15:0]   nice;
    logic [TW-1:0] nrt;
    logic [31:0]   key;
    logic [15:0]   prm;
    logic [31:0]   wv;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_WR, S_SCAN_RD, S_SCAN, S_INS_RD, S_INS, S_INS_CMP, S_SHIFT,
    S_PICK_RD, S_PICK, S_OUT
  } state_e;

  // Thread table memory, registered read.
  entry_t mem [NUM_THREADS];
  logic [IW-1:0] mem_ra, mem_wa;
  logic mem_we;
  entry_t mem_wd, mem_rd_q;
  // List order memory.
  logic [IW-1:0] ord [NUM_THREADS];
  logic [IW-1:0] ord_ra, ord_wa, ord_wd;
  logic ord_we;
  logic [IW-1:0] ord_rd_q;
  logic [IW-1:0] srt [NUM_THREADS];
  logic [IW-1:0] srt_ra, srt_wa, srt_wd, srt_rd_q;
  logic srt_we;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd_q <= mem[mem_ra];
    if (ord_we) ord[ord_wa] <= ord_wd;
    ord_rd_q <= ord[ord_ra];
    if (srt_we) srt[srt_wa] <= srt_wd;
    srt_rd_q <= srt[srt_ra];
  end

  state_e state_q;
  logic [NUM_THREADS-1:0] valid_q;
  logic [CW-1:0] total_q, i_q, k_q, p_q;
  logic active_q;
  logic [IW-1:0] act_q, cur_q;
  entry_t cur_e_q;
  logic [2:0] req_q;
  logic [7:0] pr_q;
  logic [15:0] ni_q, prm_q;
  logic [TW-1:0] now_q;
  logic [1:0] oc_q;
  logic [31:0] key_q, wv_q;
  logic wall_q, alive_q, stop_q, phase_q;
  result_t res_q;
  logic [CW-1:0] pt_q;
  logic [IW-1:0] pk_q;

  function automatic logic [1:0] tier(entry_t e, logic [TW-1:0] n);
    if (e.rs == ST_FINISHED || e.rs == ST_WAITING) return 2'd3;
    if (e.rs == ST_NOW) return 2'd1;
    if (e.nrt < n) return 2'd0;
    return 2'd2;
  endfunction
  function automatic logic goes_first(entry_t a, entry_t b, logic [TW-1:0] n);
    logic [1:0] ra, rb;
    ra = tier(a, n);
    rb = tier(b, n);
    if (ra != rb) return ra < rb;
    if ((ra == 2'd0 || ra == 2'd2) && a.nrt != b.nrt) return a.nrt < b.nrt;
    return a.prio < b.prio;
  endfunction

  logic [TW-1:0] now_ext;
  assign now_ext = TW'(now_i);
  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_OUT);
  assign res_o = res_q;

  always_comb begin
    mem_ra = cur_q; mem_we = 1'b0; mem_wa = cur_q; mem_wd = mem_rd_q;
    ord_ra = i_q[IW-1:0]; ord_we = 1'b0; ord_wa = i_q[IW-1:0]; ord_wd = cur_q;
    srt_ra = p_q[IW-1:0]; srt_we = 1'b0; srt_wa = p_q[IW-1:0]; srt_wd = cur_q;
    case (state_q)
      S_RD: mem_ra = cur_q;
      S_WR: begin
        mem_wa = cur_q;
        mem_wd = mem_rd_q;
        case (req_q)
          REQ_ADD: begin
            mem_we = valid_q[cur_q] || (total_q < CW'(NUM_THREADS));
            mem_wd = '{rs: ST_CREATED, prio: pr_q, nice: ni_q, nrt: '0,
                       key: '0, prm: '0, wv: '0};
            ord_we = !valid_q[cur_q] && (total_q < CW'(NUM_THREADS));
            ord_wa = total_q[IW-1:0];
            ord_wd = cur_q;
          end
          REQ_START: begin
            mem_we = valid_q[cur_q];
            mem_wd.rs = ST_READY;
            mem_wd.nrt = now_q;
          end
          REQ_PICK: begin
            mem_we = 1'b1;
            mem_wd.rs = ST_RUNNING;
          end
          REQ_RETURN: begin
            mem_we = 1'b1;
            if (oc_q == OC_WAIT) begin
              mem_wd.rs = ST_WAITING; mem_wd.key = key_q; mem_wd.prm = prm_q; mem_wd.wv = '0;
            end else if (oc_q == OC_FINISH) mem_wd.rs = ST_FINISHED;
            else mem_wd.rs = ST_YIELDED;
            mem_wd.nrt = now_q + TW'(mem_rd_q.nice);
          end
          default: ;
        endcase
      end
      S_SCAN_RD: ord_ra = i_q[IW-1:0];
      S_SCAN: mem_ra = ord_rd_q;
      S_INS_RD: begin ord_ra = i_q[IW-1:0]; end
      S_INS: begin mem_ra = ord_rd_q; end
      S_INS_CMP: begin srt_ra = p_q[IW-1:0]; mem_ra = srt_rd_q; end
      S_SHIFT: begin
        srt_ra = IW'(p_q - 1'b1);
        if (phase_q) begin
          srt_we = 1'b1; srt_wa = p_q[IW-1:0]; srt_wd = srt_rd_q;
        end
      end
      S_PICK_RD: begin srt_ra = i_q[IW-1:0]; end
      S_PICK: begin mem_ra = srt_rd_q; end
      default: ;
    endcase
    if (state_q == S_SCAN && req_q == REQ_NOTIFY && phase_q && !stop_q &&
        mem_rd_q.rs == ST_WAITING && mem_rd_q.key == key_q && mem_rd_q.prm == prm_q) begin
      mem_we = 1'b1; mem_wa = cur_q; mem_wd = mem_rd_q; mem_wd.rs = ST_NOW; mem_wd.wv = wv_q;
    end
    if (state_q == S_PICK && phase_q) begin
      ord_we = 1'b1; ord_wa = i_q[IW-1:0]; ord_wd = cur_q;
    end
    // The new slot lands at the insertion point, or at the end when none was found.
    if (state_q == S_SHIFT && !phase_q && (p_q == pt_q || !alive_q)) begin
      srt_we = 1'b1; srt_wa = p_q[IW-1:0]; srt_wd = cur_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; valid_q <= '0; total_q <= '0; active_q <= 1'b0; act_q <= '0;
      i_q <= '0; k_q <= '0; p_q <= '0; cur_q <= '0; phase_q <= 1'b0; stop_q <= 1'b0;
      alive_q <= 1'b0; res_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: if (start_i) begin
          req_q <= req_type_i; pr_q <= priority_req_i; ni_q <= nice_i;
          now_q <= now_ext; oc_q <= outcome_i; key_q <= wait_key_i; prm_q <= wait_param_i;
          wv_q <= wake_value_i; wall_q <= wake_all_i;
          i_q <= '0; k_q <= '0; phase_q <= 1'b0; stop_q <= 1'b0;
          alive_q <= 1'b0;
          case (req_type_i)
            REQ_ADD: if (32'(thread_id_i) < NUM_THREADS) begin
              cur_q <= IW'(thread_id_i); state_q <= S_RD;
            end else state_q <= S_OUT;
            REQ_START: if (active_q) begin
              res_q.status <= STAT_BUSY; state_q <= S_OUT;
            end else begin cur_q <= '0; state_q <= S_RD; end
            REQ_PICK: if (active_q) begin
              res_q.status <= STAT_BUSY; state_q <= S_OUT;
            end else if (total_q == '0) begin
              res_q.status <= STAT_ALL_FIN; state_q <= S_OUT;
            end else state_q <= S_INS_RD;
            REQ_RETURN: if (!active_q) begin
              res_q.status <= STAT_NO_RUN; state_q <= S_OUT;
            end else begin cur_q <= act_q; state_q <= S_RD; end
            REQ_NOTIFY: if (!active_q) begin
              res_q.status <= STAT_NO_RUN; state_q <= S_OUT;
            end else state_q <= S_SCAN_RD;
            default: state_q <= S_OUT;
          endcase
        end
        S_RD: state_q <= S_WR;
        S_WR: begin
          if (req_q == REQ_ADD && !valid_q[cur_q] && total_q < CW'(NUM_THREADS)) begin
            valid_q[cur_q] <= 1'b1; total_q <= total_q + 1'b1;
          end
          if (req_q == REQ_START && 32'(cur_q) < NUM_THREADS - 1) begin
            cur_q <= cur_q + 1'b1; state_q <= S_RD;
          end else if (req_q == REQ_PICK) begin
            res_q.status <= STAT_RUN; res_q.chosen_thread <= 3'(cur_q);
            res_q.urgency <= tier(mem_rd_q, now_q);
            res_q.sleep_time <= (mem_rd_q.rs != ST_NOW && mem_rd_q.nrt > now_q) ?
                                32'(mem_rd_q.nrt - now_q) : '0;
            res_q.resume_value <= mem_rd_q.wv;
            active_q <= 1'b1; act_q <= cur_q; state_q <= S_OUT;
          end else begin
            if (req_q == REQ_RETURN) active_q <= 1'b0;
            state_q <= S_OUT;
          end
        end
        // Notify walk over the list order.
        S_SCAN_RD: if (i_q >= total_q || stop_q) state_q <= S_OUT;
          else begin phase_q <= 1'b0; state_q <= S_SCAN; end
        S_SCAN: if (!phase_q) begin
          cur_q <= ord_rd_q; phase_q <= 1'b1;
        end else begin
          if (mem_rd_q.rs == ST_WAITING && mem_rd_q.key == key_q && mem_rd_q.prm == prm_q) begin
            res_q.woken_count <= res_q.woken_count + 1'b1;
            if (!wall_q) stop_q <= 1'b1;
          end
          i_q <= i_q + 1'b1; state_q <= S_SCAN_RD;
        end
        // Insertion sort: for each listed slot, find its place in the sorted copy.
        S_INS_RD: if (i_q >= total_q) begin
          i_q <= '0; phase_q <= 1'b0; state_q <= S_PICK_RD;
        end else begin phase_q <= 1'b0; state_q <= S_INS; end
        S_INS: if (!phase_q) begin
          cur_q <= ord_rd_q; phase_q <= 1'b1;
        end else begin
          cur_e_q <= mem_rd_q; p_q <= '0; phase_q <= 1'b0; state_q <= S_INS_CMP;
        end
        S_INS_CMP: if (p_q >= k_q) begin
          phase_q <= 1'b0; p_q <= k_q; state_q <= S_SHIFT;
        end else if (!phase_q) phase_q <= 1'b1;
        else if (!stop_q) begin
          stop_q <= 1'b1;
        end else begin
          stop_q <= 1'b0; phase_q <= 1'b0;
          if (goes_first(cur_e_q, mem_rd_q, now_q)) begin
            // alive_q marks that an insertion point was found.
            pt_q <= p_q; p_q <= k_q; alive_q <= 1'b1; state_q <= S_SHIFT;
          end else p_q <= p_q + 1'b1;
        end
        // Shift entries up from k down to the insertion point.
        S_SHIFT: begin
          if (p_q == pt_q || !alive_q) begin
            phase_q <= 1'b0; alive_q <= 1'b0; k_q <= k_q + 1'b1; i_q <= i_q + 1'b1;
            state_q <= S_INS_RD;
          end else if (!phase_q) phase_q <= 1'b1;
          else begin phase_q <= 1'b0; p_q <= p_q - 1'b1; end
        end
        // Write sorted order back and take the first runnable thread.
        S_PICK_RD: if (i_q >= total_q) begin
          res_q.status <= alive_q ? STAT_ALL_WAIT : STAT_ALL_FIN;
          if (!stop_q) state_q <= S_OUT; else state_q <= S_RD;
        end else begin phase_q <= 1'b0; state_q <= S_PICK; end
        S_PICK: if (!phase_q) begin
          cur_q <= srt_rd_q; phase_q <= 1'b1;
        end else begin
          if (!stop_q && mem_rd_q.rs != ST_FINISHED) begin
            alive_q <= 1'b1;
            if (mem_rd_q.rs != ST_WAITING) begin stop_q <= 1'b1; pk_q <= cur_q; end
          end
          i_q <= i_q + 1'b1; state_q <= S_PICK_RD;
        end
        S_OUT: begin
          res_q <= '0; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      if (state_q == S_PICK_RD && i_q >= total_q && stop_q) cur_q <= pk_q;
    end
  end
endmodule
`default_nettype wire

// File: design/urgency_tier_thread_scheduler_top.sv
// Top level of the urgency-tier thread scheduler: stream ports and result register.
//
// One request travels on the slave stream (s_axis_*) and gives exactly one
// result on the master stream (m_axis_*). A request is taken only while the
// sequencer is idle and the result register is free.
// Add and return read and write one table entry; start visits every entry
// in turn; notify walks the list order; a request refused at once (busy,
// nothing running, empty table) goes straight to the result.
// Pick runs an insertion sort over the list order held in a small memory and
// then a scan over the sorted copy, which writes the sorted order back.
// The next request is accepted once the result transfer clears the output valid register.
// Reset empties the table and clears the running thread; no clearing pass
// is needed. When the receiver stalls, the finished result waits in the
// output register and the next request is held off until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module urgency_tier_thread_scheduler_top import uts_pkg::*; #(
  parameter int NUM_THREADS = 8,
  parameter int TIME_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // req_type, thread_id, priority_req, nice, now, outcome, wait_key,
  // wait_param, wake_value, wake_all (lowest first)
  input  wire logic [InBytes*8-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // status, chosen_thread, sleep_time, urgency, resume_value, woken_count
  output logic [OutBytes*8-1:0]      m_axis_tdata
);
  logic busy, done, out_v_q, take;
  result_t res;
  logic [OutBits-1:0] out_q;

  assign s_axis_tready = !busy && !out_v_q;
  assign take = s_axis_tvalid && s_axis_tready;

  uts_core #(.NUM_THREADS(NUM_THREADS), .TIME_BITS(TIME_BITS)) u_core (
    .clk_i, .rst_ni, .start_i(take),
    .req_type_i(s_axis_tdata[2:0]), .thread_id_i(s_axis_tdata[5:3]),
    .priority_req_i(s_axis_tdata[13:6]), .nice_i(s_axis_tdata[29:14]),
    .now_i(s_axis_tdata[61:30]), .outcome_i(s_axis_tdata[63:62]),
    .wait_key_i(s_axis_tdata[95:64]), .wait_param_i(s_axis_tdata[111:96]),
    .wake_value_i(s_axis_tdata[143:112]), .wake_all_i(s_axis_tdata[144]),
    .busy_o(busy), .done_o(done), .res_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (done) out_v_q <= 1'b1;
    else if (m_axis_tready) out_v_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (done) out_q <= {res.woken_count, res.resume_value, res.urgency,
                        res.sleep_time, res.chosen_thread, res.status};
  end
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = {{(OutBytes*8-OutBits){1'b0}}, out_q};
endmodule
`default_nettype wire
